FILE: design/pcca_pkg.sv
// Shared types, widths and helpers for the PI code confidence averager.
package pcca_pkg;

    localparam int RATIO_FRAC_BITS = 14;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 2;   // sign + integer bit + fraction
    localparam int SUM_W           = 8;
    localparam int WGT_W           = 4;
    localparam int DEN_W           = SUM_W + 1;
    localparam int NUM_W           = RATIO_W + SUM_W + 1;   // ratio * sum + weight term
    localparam int LANES           = 16;
    localparam int THR_W           = 15;
    localparam int CMP_W           = (RATIO_W > THR_W) ? RATIO_W : THR_W;
    localparam int CNT_W           = $clog2(NUM_W);
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 15;

    localparam logic [SUM_W-1:0]     SUM_MAX       = '1;
    localparam logic [SUM_W-1:0]     MIN_SUM_RST   = 8'd32;
    localparam logic [THR_W-1:0]     THR_RST       = 15'd14746;
    localparam logic [1:0]           ERR_NONE      = 2'd0;
    localparam logic [1:0]           ERR_ONE       = 2'd1;
    localparam logic [1:0]           ERR_TWO       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUM   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    typedef logic signed [RATIO_W-1:0] t_ratio;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_MRG,
        ST_WB
    } t_state;

    typedef struct packed {
        logic mul;      // register ratio * old sum
        logic num;      // add weight term, split sign and magnitude
        logic step;     // one restoring division step
        logic commit;   // write new ratio
    } t_lane_ctl;

    function automatic logic [WGT_W-1:0] weight_of(input logic [1:0] errs);
        logic [WGT_W-1:0] w;
        case (errs)
            ERR_ONE: w = WGT_W'(8);
            ERR_TWO: w = WGT_W'(2);
            default: w = WGT_W'(1);
        endcase
        return w;
    endfunction

endpackage

FILE: design/pi_code_confidence_averager_top.sv
// Top level: control sequencer, weight sum, config registers, lanes and output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_pi_word, i_error_count
//  out     | output    | o_out_valid / i_out_ready | o_pi_value, o_is_reliable
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A clean word goes from accept straight to write-back and the output register; a word with
// errors first passes through multiply, add, the bit-serial divider that all 16 lanes run in
// lockstep, commit and merge. One word is in flight at a time.
// Reset clears ratios, weight sum and output valid, and loads the config registers with their defaults.
// A stalled output holds the sequencer in its write-back state until taken.
module pi_code_confidence_averager_top
    import pcca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_pi_word,
    input  logic [1:0]            i_error_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_pi_value,
    output logic                  o_is_reliable,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_word;
    logic             r_clean;
    logic [SUM_W-1:0] r_s;
    logic [WGT_W-1:0] r_w;
    logic [DEN_W-1:0] r_den;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_min;
    logic [THR_W-1:0] r_thr;
    logic             r_out_valid;
    logic [15:0]      r_out_value;
    logic             r_out_rel;
    logic             r_wb_hold;

    t_lane_ctl        lane_ctl;
    logic             accept;
    logic             out_free;
    logic             merge_en;
    logic [WGT_W-1:0] w_in;
    logic [DEN_W-1:0] den_in;
    t_ratio           ratio [LANES];
    logic [LANES-1:0] m_value;
    logic             m_rel;

    assign accept   = i_in_valid & o_in_ready;
    assign out_free = ~r_out_valid | i_out_ready;
    assign w_in     = weight_of(i_error_count);
    assign den_in   = DEN_W'(r_sum) + DEN_W'(w_in);

    always_comb begin
        n_state    = r_state;
        lane_ctl   = '0;
        merge_en   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_error_count == ERR_NONE) ? ST_WB : ST_MUL;
                end
            end
            ST_MUL: begin
                lane_ctl.mul = 1'b1;
                n_state      = ST_ADD;
            end
            ST_ADD: begin
                lane_ctl.num = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                lane_ctl.step = 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_MRG;
                end
            end
            ST_MRG: begin
                // lanes commit now; merge samples the committed ratios next cycle
                lane_ctl.commit = 1'b1;
                n_state         = ST_WB;
            end
            ST_WB: begin
                merge_en = ~r_clean;
                if (out_free && !r_wb_hold) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == ST_DIV) begin
            r_cnt <= (r_cnt == CNT_W'(NUM_W - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (accept && i_error_count != ERR_NONE) begin
            r_sum <= (den_in > DEN_W'(SUM_MAX)) ? SUM_MAX : den_in[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_pi_word;
            r_clean <= (i_error_count == ERR_NONE);
            r_s     <= r_sum;
            r_w     <= w_in;
            r_den   <= den_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_SUM_RST;
            r_thr <= THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_SUM:   r_min <= i_cfg_data[SUM_W-1:0];
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // r_wb_hold marks the write-back cycle in which the merge registers its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_hold <= 1'b0;
        end else begin
            r_wb_hold <= (r_state == ST_MRG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_WB && out_free && !r_wb_hold) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB && out_free && !r_wb_hold) begin
            r_out_value <= r_clean ? r_word : m_value;
            r_out_rel   <= r_clean | m_rel;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            pcca_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lane_ctl),
                .i_bit   (r_word[g]),
                .i_s     (r_s),
                .i_w     (r_w),
                .i_den   (r_den),
                .o_ratio (ratio[g])
            );
        end
    endgenerate

    pcca_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (merge_en & r_wb_hold),
        .i_ratio     (ratio),
        .i_sum_ok    (r_sum >= r_min),
        .i_threshold (r_thr),
        .o_value     (m_value),
        .o_reliable  (m_rel)
    );

    assign o_out_valid   = r_out_valid;
    assign o_pi_value    = r_out_value;
    assign o_is_reliable = r_out_rel;

endmodule

FILE: design/pcca_lane.sv
// One bit lane: holds a bit ratio and updates it with a serial restoring divider.
module pcca_lane
    import pcca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic             i_bit,
    input  logic [SUM_W-1:0] i_s,
    input  logic [WGT_W-1:0] i_w,
    input  logic [DEN_W-1:0] i_den,
    output t_ratio           o_ratio
);

    t_ratio                   r_ratio;
    logic signed [NUM_W-1:0]  r_prod;
    logic [NUM_W-1:0]         r_q;      // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0]         r_rem;
    logic                     r_neg;

    logic signed [NUM_W-1:0]  n_prod;
    logic signed [NUM_W-1:0]  term;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           trial;
    logic [RATIO_W-1:0]       q_mag;

    always_comb begin
        n_prod = $signed({{(NUM_W-RATIO_W){r_ratio[RATIO_W-1]}}, r_ratio})
               * $signed({{(NUM_W-SUM_W){1'b0}}, i_s});
        term   = $signed(NUM_W'(i_w) << RATIO_FRAC_BITS);
        num    = i_bit ? (r_prod + term) : (r_prod - term);
        rem_sh = {r_rem, r_q[NUM_W-1]};
        trial  = rem_sh - {1'b0, i_den};
        // quotient magnitude never exceeds one in ratio format
        q_mag  = {1'b0, r_q[RATIO_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= '0;
        end else if (i_ctl.commit) begin
            r_ratio <= r_neg ? t_ratio'(-q_mag) : t_ratio'(q_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
        if (i_ctl.num) begin
            r_neg <= num[NUM_W-1];
            r_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r_rem <= '0;
        end else if (i_ctl.step) begin
            if (!trial[DEN_W]) begin
                r_rem <= trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_ratio = r_ratio;

endmodule

FILE: design/pcca_merge.sv
// Merge stage: rebuilds the word from lane signs and checks lane confidence.
module pcca_merge
    import pcca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_ratio           i_ratio [LANES],
    input  logic             i_sum_ok,
    input  logic [THR_W-1:0] i_threshold,
    output logic [LANES-1:0] o_value,
    output logic             o_reliable
);

    logic [LANES-1:0] n_value;
    logic [LANES-1:0] conf;
    logic [CMP_W-1:0] mag [LANES];

    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            n_value[b] = ~i_ratio[b][RATIO_W-1];
            mag[b]     = i_ratio[b][RATIO_W-1] ? CMP_W'(-i_ratio[b]) : CMP_W'(i_ratio[b]);
            conf[b]    = mag[b] >= CMP_W'(i_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value    <= n_value;
            o_reliable <= i_sum_ok & (&conf);
        end
    end

endmodule

FILE: verif/pi_code_confidence_averager_top_test.sv
// Self-checking testbench for the PI code confidence averager: directed table, then random phases.
module pi_code_confidence_averager_top_test;
    import pcca_pkg::*;

    localparam logic [1:0] ERR_THREE       = 2'd3;
    localparam int         ITEMS_PER_PHASE = 150;
    localparam int         NUM_PHASES      = 13;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         MAX_PRINTED     = 100;
    localparam int         NUM_DIR_ROWS    = 16;

    typedef struct packed {
        logic [15:0] pi_value;
        logic        is_reliable;
    } t_averaged_word;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  errs;
        logic        typed;
        logic [15:0] exp_value;
        logic        exp_rel;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    // typed rows: output readable straight from the inputs; others go through the predictor
    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{16'h0000, ERR_NONE,  1'b1, 16'h0000, 1'b1},
        '{16'hFFFF, ERR_NONE,  1'b1, 16'hFFFF, 1'b1},
        '{16'hA5A5, ERR_NONE,  1'b1, 16'hA5A5, 1'b1},
        '{16'h1234, ERR_ONE,   1'b1, 16'h1234, 1'b0},   // ratios jump to +-1.0
        '{16'h1234, ERR_ONE,   1'b1, 16'h1234, 1'b0},
        '{16'h1234, ERR_ONE,   1'b1, 16'h1234, 1'b0},
        '{16'h1234, ERR_ONE,   1'b1, 16'h1234, 1'b1},   // sum hits the minimum
        '{16'h5A5A, ERR_NONE,  1'b1, 16'h5A5A, 1'b1},   // clean word, averages untouched
        '{16'h1234, ERR_ONE,   1'b1, 16'h1234, 1'b1},
        '{16'h1235, ERR_TWO,   1'b0, 16'h0000, 1'b0},
        '{16'hEDCB, ERR_THREE, 1'b0, 16'h0000, 1'b0},
        '{16'hFFFF, ERR_THREE, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, ERR_TWO,   1'b0, 16'h0000, 1'b0},
        '{16'h8001, ERR_ONE,   1'b0, 16'h0000, 1'b0},
        '{16'h0001, ERR_THREE, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, ERR_ONE,   1'b0, 16'h0000, 1'b0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [15:0]           i_pi_word;
    logic [1:0]            i_error_count;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [15:0]           o_pi_value;
    logic                  o_is_reliable;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    t_ratio         ratio_est [LANES];
    logic [SUM_W-1:0] weight_acc;
    logic [SUM_W-1:0] min_sum_reg;
    logic [THR_W-1:0] thr_reg;

    t_averaged_word pending_words [$];
    int             mismatch_count;
    int             idle_cycles;
    int             burst_left;
    t_rx_mode       rx_mode;
    int             rx_left;
    logic [7:0]     rx_pattern;
    int             rx_phase;

    pi_code_confidence_averager_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pi_word     (i_pi_word),
        .i_error_count (i_error_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pi_value    (o_pi_value),
        .o_is_reliable (o_is_reliable),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_averaged_word average_word(input logic [15:0] word,
                                                    input logic [1:0] errs);
        t_averaged_word res;
        int             wgt;
        int             old_sum;
        int             den;
        int             num;
        int             mag;
        int             b;
        t_ratio         upd;
        res.pi_value    = word;
        res.is_reliable = 1'b1;
        if (errs == ERR_NONE) return res;
        case (errs)
            ERR_ONE: wgt = 8;
            ERR_TWO: wgt = 2;
            default: wgt = 1;
        endcase
        old_sum = int'(weight_acc);
        // divisor is the exact sum, the stored sum saturates
        den = old_sum + wgt;
        weight_acc = (den > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(den);
        res.is_reliable = (weight_acc >= min_sum_reg);
        for (b = 0; b < LANES; b++) begin
            num = int'(ratio_est[b]) * old_sum
                + (word[b] ? wgt : -wgt) * (1 << RATIO_FRAC_BITS);
            upd = t_ratio'(num / den);
            ratio_est[b] = upd;
            res.pi_value[b] = (upd >= 0);
            mag = (upd < 0) ? -int'(upd) : int'(upd);
            if (mag < int'(thr_reg)) res.is_reliable = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [15:0] word, input logic [1:0] errs,
                             input logic use_typed, input t_averaged_word typed_exp);
        int             gap;
        t_averaged_word pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_pi_word     <= word;
        i_error_count <= errs;
        do @(posedge i_clk); while (!o_in_ready);
        pred = average_word(word, errs);
        pending_words.push_back(use_typed ? typed_exp : pred);
    endtask

    // drop valid and wait for every expected word, then let the block settle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_MIN_SUM) min_sum_reg = data[SUM_W-1:0];
        else if (idx == CFG_THRESHOLD) thr_reg = data[THR_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] min_data,
                                 input logic [CFG_DATA_W-1:0] thr_data);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(CFG_MIN_SUM, min_data);
            write_reg(CFG_THRESHOLD, thr_data);
        end else begin
            write_reg(CFG_THRESHOLD, thr_data);
            write_reg(CFG_MIN_SUM, min_data);
        end
    endtask

    // receiver: a stall mode held for a while, then another
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left == 0) begin
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            rx_left    = $urandom_range(50, 300);
            rx_pattern = 8'($urandom) | 8'h01;
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_ALWAYS:  rdy = 1'b1;
            RX_COIN:    rdy = 1'($urandom_range(0, 1));
            RX_PATTERN: rdy = rx_pattern[rx_phase % 8];
            default:    rdy = ($urandom_range(0, 15) == 0);
        endcase
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        t_averaged_word exp_word;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h rel %b", o_pi_value, o_is_reliable));
            end else begin
                exp_word = pending_words.pop_front();
                if (o_pi_value != exp_word.pi_value)
                    report_mismatch($sformatf("pi_value %h, expected %h",
                                              o_pi_value, exp_word.pi_value));
                if (o_is_reliable != exp_word.is_reliable)
                    report_mismatch($sformatf("is_reliable %b, expected %b (word %h)",
                                              o_is_reliable, exp_word.is_reliable,
                                              exp_word.pi_value));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("pi_code_confidence_averager_top_test NOT OK");
            $finish;
        end
    end

    initial begin
        t_averaged_word   typed_exp;
        logic [15:0]      station;
        logic [15:0]      word;
        logic [15:0]      flips;
        logic [CFG_DATA_W-1:0] min_data;
        logic [CFG_DATA_W-1:0] thr_data;
        int               pick;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_pi_word      = '0;
        i_error_count  = ERR_NONE;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MIN_SUM;
        i_cfg_data     = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        rx_left        = 0;
        rx_phase       = 0;
        rx_mode        = RX_ALWAYS;
        rx_pattern     = 8'hFF;
        for (int b = 0; b < LANES; b++) ratio_est[b] = '0;
        weight_acc  = '0;
        min_sum_reg = MIN_SUM_RST;
        thr_reg     = THR_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            typed_exp.pi_value    = DIR_ROWS[i].exp_value;
            typed_exp.is_reliable = DIR_ROWS[i].exp_rel;
            send_word(DIR_ROWS[i].word, DIR_ROWS[i].errs, DIR_ROWS[i].typed, typed_exp);
        end
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin min_data = 15'd255;   thr_data = 15'd0;     end  // sum still growing
                1: begin min_data = 15'd0;     thr_data = 15'd0;     end
                2: begin min_data = 15'd255;   thr_data = 15'd16384; end
                3: begin min_data = 15'd0;     thr_data = 15'd32767; end  // can never be met
                4: begin min_data = 15'h7F20;  thr_data = 15'd14746; end  // upper bits dropped
                5: begin min_data = 15'd0;     thr_data = 15'd1;     end
                default: begin
                    min_data = CFG_DATA_W'($urandom_range(0, 32767));
                    thr_data = ($urandom_range(0, 3) == 0) ?
                               CFG_DATA_W'($urandom_range(0, 32767)) :
                               CFG_DATA_W'($urandom_range(12000, 16384));
                end
            endcase
            set_registers(min_data, thr_data);
            station = 16'($urandom);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    // the same station with a few bits hit by noise
                    flips = 16'($urandom & $urandom & $urandom & $urandom);
                    word  = station ^ flips;
                end else if (pick < 82) begin
                    station = 16'($urandom);
                    word    = station;
                end else begin
                    word = 16'($urandom);
                end
                send_word(word, 2'($urandom_range(0, 3)), 1'b0, '0);
            end
            settle();
        end

        repeat (NUM_W + 8) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
        if (mismatch_count == 0) begin
            $display("pi_code_confidence_averager_top_test OK");
        end else begin
            $display("pi_code_confidence_averager_top_test NOT OK");
        end
        $finish;
    end

endmodule
